// ===== src/pidb_pkg.sv =====
package pidb_pkg;

  // APB address width: six 32-bit registers at 4-byte spacing
  localparam int ADDR_W = 5;
  localparam int GAIN_W = 24;
  localparam int BAND_W = 31;
  localparam int ERR_W  = 33;

  // register indexes (paddr[4:2])
  localparam logic [2:0] REG_KP       = 3'd0;
  localparam logic [2:0] REG_KI       = 3'd1;
  localparam logic [2:0] REG_KD       = 3'd2;
  localparam logic [2:0] REG_MODE     = 3'd3;
  localparam logic [2:0] REG_BAND     = 3'd4;
  localparam logic [2:0] REG_PWM_MAX  = 3'd5;

  // control modes
  localparam logic [1:0] MODE_PID   = 2'd0;  // plain PID
  localparam logic [1:0] MODE_BAND  = 2'd1;  // I and D only inside band
  localparam logic [1:0] MODE_FORCE = 2'd2;  // integrate inside band, full scale above band
  localparam logic [1:0] MODE_HALF  = 2'd3;  // half ki outside band, full scale above band + 1.0

  localparam logic [31:0] BAND_RST = 32'd65536;

  typedef struct packed {
    logic signed [GAIN_W-1:0] kp;
    logic signed [GAIN_W-1:0] ki;
    logic signed [GAIN_W-1:0] kd;
    logic [1:0]               mode;
    logic [BAND_W-1:0]        band;
  } cfg_t;

  // state clear requests raised by register writes
  typedef struct packed {
    logic integ;  // ki written
    logic all;    // control_mode written
  } clr_t;

endpackage

// ===== src/pid_controller_banded_integral.sv =====
// PID controller with banded (conditional) integration.
//
// Input channel: in_valid_i / in_stall_o carry one transaction of setpoint_i
// and measurement_i (signed Q16.16). Output channel: out_valid_o / out_stall_i
// carry duty_o, raw_drive_o and in_band_o for each input transaction, in order.
// A transaction moves at a rising edge with valid high and stall low.
//
// Path: a taken input is loaded into the input register, and the result of
// one pass of the step logic is loaded from there into the result register
// once the result register is free or drains.
// Throughput: one transaction per cycle while the receiver does not stall.
// The previous error, integral and band flag update in the same cycle as the
// step that uses them, which is what lets the next sample follow directly.
//
// When the receiver stalls, the result register holds and the input register
// can still take one more sample; only with both full is in_stall_o raised.
//
// Reset clears the pipeline, the controller state and the registers to their
// defaults (gains 0, mode 0, band 1.0, pwm_max 65535). Write the registers
// over the APB port only while the block is idle (not enforced); writing ki
// clears the integral, writing control_mode clears all controller state.
module pid_controller_banded_integral #(
  parameter int FRAC_BITS = 16,
  parameter int PWM_BITS  = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // configuration
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [pidb_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  // samples
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic signed [31:0]          setpoint_i,
  input  logic signed [31:0]          measurement_i,
  // results
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [PWM_BITS:0]           duty_o,
  output logic signed [31:0]          raw_drive_o,
  output logic                        in_band_o
);

  localparam int EW = pidb_pkg::ERR_W;

  pidb_pkg::cfg_t      cfg;
  pidb_pkg::clr_t      clr;
  logic [PWM_BITS-1:0] pwm_max;

  pidb_cfg #(.PWM_BITS(PWM_BITS)) u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .cfg_o     (cfg),
    .pwm_max_o (pwm_max),
    .clr_o     (clr)
  );

  // input register
  logic               in_vld_q;
  logic signed [31:0] sp_q;
  logic signed [31:0] ms_q;

  // controller state
  logic signed [EW-1:0] prev_err_q;
  logic signed [47:0]   integ_q;
  logic                 flag_q;

  // result register
  logic               out_vld_q;
  logic [PWM_BITS:0]  duty_q;
  logic signed [31:0] raw_q;
  logic               band_q;

  logic signed [EW-1:0] err_d;
  logic signed [47:0]   integ_d;
  logic                 flag_d;
  logic [PWM_BITS:0]    duty_d;
  logic signed [31:0]   raw_d;

  logic advance;
  logic take;

  // the held sample moves on whenever the result register is free or drains
  assign advance    = in_vld_q && (!out_vld_q || !out_stall_i);
  assign take       = in_valid_i && !in_stall_o;
  assign in_stall_o = in_vld_q && out_vld_q && out_stall_i;

  pidb_step #(.FRAC_BITS(FRAC_BITS), .PWM_BITS(PWM_BITS)) u_step (
    .cfg_i         (cfg),
    .pwm_max_i     (pwm_max),
    .setpoint_i    (sp_q),
    .measurement_i (ms_q),
    .prev_err_i    (prev_err_q),
    .integ_i       (integ_q),
    .flag_i        (flag_q),
    .err_o         (err_d),
    .integ_o       (integ_d),
    .flag_o        (flag_d),
    .duty_o        (duty_d),
    .raw_drive_o   (raw_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (take) begin
      in_vld_q <= 1'b1;
    end else if (advance) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      sp_q <= setpoint_i;
      ms_q <= measurement_i;
    end
  end

  // write registers only while idle (not enforced); writes win over a step
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_err_q <= '0;
      integ_q    <= '0;
      flag_q     <= 1'b0;
    end else if (clr.all) begin
      prev_err_q <= '0;
      integ_q    <= '0;
      flag_q     <= 1'b0;
    end else if (clr.integ) begin
      integ_q <= '0;
    end else if (advance) begin
      prev_err_q <= err_d;
      integ_q    <= integ_d;
      flag_q     <= flag_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      duty_q <= duty_d;
      raw_q  <= raw_d;
      band_q <= flag_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign duty_o      = duty_q;
  assign raw_drive_o = raw_q;
  assign in_band_o   = band_q;

  // the reported flag is the state the step left behind
  a_band_matches_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && !clr.all |=> in_band_o == flag_q)
    else $error("in_band_o disagrees with band flag state");

  // mode 0 never moves the band flag
  a_mode0_flag_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && !clr.all && cfg.mode == pidb_pkg::MODE_PID
    |=> flag_q == $past(flag_q))
    else $error("band flag changed in plain PID mode");

  // mode 1 outside the band holds the integral
  a_mode1_integ_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && !clr.all && !clr.integ && cfg.mode == pidb_pkg::MODE_BAND && !flag_d
    |=> integ_q == $past(integ_q))
    else $error("integral moved outside the band in mode 1");

  // a negative drive always gives zero duty
  a_neg_drive_zero_duty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && raw_drive_o[31] |-> duty_o == '0)
    else $error("negative drive with nonzero duty");

endmodule

// ===== src/pidb_cfg.sv =====
module pidb_cfg #(
  parameter int PWM_BITS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [pidb_pkg::ADDR_W-1:0]  paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  output pidb_pkg::cfg_t               cfg_o,
  output logic [PWM_BITS-1:0]          pwm_max_o,
  output pidb_pkg::clr_t               clr_o
);

  localparam logic [PWM_BITS-1:0] PWM_RST = PWM_BITS'(32'd65535);

  pidb_pkg::cfg_t      cfg_q;
  logic [PWM_BITS-1:0] pwm_max_q;
  logic                wr;
  logic [2:0]          idx;

  assign wr     = psel && penable && pwrite;
  assign idx    = paddr[4:2];
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.kp   <= '0;
      cfg_q.ki   <= '0;
      cfg_q.kd   <= '0;
      cfg_q.mode <= pidb_pkg::MODE_PID;
      cfg_q.band <= pidb_pkg::BAND_RST[pidb_pkg::BAND_W-1:0];
      pwm_max_q  <= PWM_RST;
    end else if (wr) begin
      unique case (idx)
        pidb_pkg::REG_KP:      cfg_q.kp   <= pwdata[pidb_pkg::GAIN_W-1:0];
        pidb_pkg::REG_KI:      cfg_q.ki   <= pwdata[pidb_pkg::GAIN_W-1:0];
        pidb_pkg::REG_KD:      cfg_q.kd   <= pwdata[pidb_pkg::GAIN_W-1:0];
        pidb_pkg::REG_MODE:    cfg_q.mode <= pwdata[1:0];
        pidb_pkg::REG_BAND:    cfg_q.band <= pwdata[pidb_pkg::BAND_W-1:0];
        pidb_pkg::REG_PWM_MAX: pwm_max_q  <= pwdata[PWM_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      pidb_pkg::REG_KP:      prdata = 32'(unsigned'(cfg_q.kp));
      pidb_pkg::REG_KI:      prdata = 32'(unsigned'(cfg_q.ki));
      pidb_pkg::REG_KD:      prdata = 32'(unsigned'(cfg_q.kd));
      pidb_pkg::REG_MODE:    prdata = 32'(cfg_q.mode);
      pidb_pkg::REG_BAND:    prdata = 32'(cfg_q.band);
      pidb_pkg::REG_PWM_MAX: prdata = 32'(pwm_max_q);
      default:               prdata = '0;
    endcase
  end

  assign clr_o.integ = wr && (idx == pidb_pkg::REG_KI);
  assign clr_o.all   = wr && (idx == pidb_pkg::REG_MODE);
  assign cfg_o       = cfg_q;
  assign pwm_max_o   = pwm_max_q;

endmodule

// ===== src/pidb_step.sv =====
module pidb_step #(
  parameter int FRAC_BITS = 16,
  parameter int PWM_BITS  = 16
) (
  input  pidb_pkg::cfg_t                    cfg_i,
  input  logic [PWM_BITS-1:0]               pwm_max_i,
  input  logic signed [31:0]                setpoint_i,
  input  logic signed [31:0]                measurement_i,
  input  logic signed [pidb_pkg::ERR_W-1:0] prev_err_i,
  input  logic signed [47:0]                integ_i,
  input  logic                              flag_i,
  output logic signed [pidb_pkg::ERR_W-1:0] err_o,
  output logic signed [47:0]                integ_o,
  output logic                              flag_o,
  output logic [PWM_BITS:0]                 duty_o,
  output logic signed [31:0]                raw_drive_o
);

  localparam int EW  = pidb_pkg::ERR_W;
  localparam int DW  = EW + 1;
  localparam int PW  = pidb_pkg::GAIN_W + EW;   // gain * e
  localparam int DPW = pidb_pkg::GAIN_W + DW;   // gain * d
  localparam int PDW = DPW + 1;
  localparam int SW  = PW + 1;                  // integral sum before saturation
  localparam int TW  = ((PDW > 48 + FRAC_BITS) ? PDW : 48 + FRAC_BITS) + 1;
  localparam int QW  = TW - 2 * FRAC_BITS;
  localparam int DRW = ((QW > 33) ? QW : 33) + 1;
  localparam logic signed [DW-1:0] ONE_Q = DW'(1) <<< FRAC_BITS;

  logic signed [EW-1:0]    e;
  logic signed [DW-1:0]    d;
  logic [EW-1:0]           ae;
  logic signed [DW-1:0]    band_s;
  logic signed [PW-1:0]    p_term;
  logic signed [PW-1:0]    i_prod;
  logic signed [DPW-1:0]   d_term;
  logic signed [PW-1:0]    inc;
  logic                    do_int;
  logic signed [SW-1:0]    sum;
  logic                    sum_ovf;
  logic signed [47:0]      integ_new;
  logic signed [47:0]      integ_use;
  logic signed [PDW-1:0]   pd_sel;
  logic signed [TW-1:0]    total;
  logic signed [QW-1:0]    q;
  logic                    rnd;
  logic                    forced;
  logic [PWM_BITS:0]       full;
  logic signed [DRW-1:0]   drv;
  logic signed [DRW-1:0]   pwm_ext;
  logic                    raw_ovf;

  assign e      = EW'(setpoint_i) - EW'(measurement_i);
  assign d      = DW'(e) - DW'(prev_err_i);
  assign ae     = e[EW-1] ? EW'(-e) : EW'(e);
  assign band_s = $signed(DW'(cfg_i.band));

  assign p_term = PW'(cfg_i.kp) * PW'(e);
  assign i_prod = PW'(cfg_i.ki) * PW'(e);
  assign d_term = DPW'(cfg_i.kd) * DPW'(d);

  // band flag outside mode 0: set strictly inside, clear strictly outside, hold on the edge
  always_comb begin
    flag_o = flag_i;
    if (cfg_i.mode != pidb_pkg::MODE_PID) begin
      if (ae < EW'(cfg_i.band)) flag_o = 1'b1;
      if (ae > EW'(cfg_i.band)) flag_o = 1'b0;
    end
  end

  always_comb begin
    inc    = i_prod >>> FRAC_BITS;
    do_int = flag_o;
    forced = 1'b0;
    unique case (cfg_i.mode)
      pidb_pkg::MODE_PID:   do_int = 1'b1;
      pidb_pkg::MODE_BAND:  do_int = flag_o;
      pidb_pkg::MODE_FORCE: forced = DW'(e) > band_s;
      pidb_pkg::MODE_HALF: begin
        do_int = 1'b1;
        if (!flag_o) inc = i_prod >>> (FRAC_BITS + 1);
        forced = DW'(e) > (band_s + ONE_Q);
      end
      default: ;
    endcase
  end

  // saturating integral update
  assign sum     = SW'(integ_i) + SW'(inc);
  assign sum_ovf = !((&sum[SW-1:47]) || !(|sum[SW-1:47]));
  always_comb begin
    if (!do_int)      integ_new = integ_i;
    else if (sum_ovf) integ_new = sum[SW-1] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
    else              integ_new = sum[47:0];
  end
  assign integ_o = integ_new;
  assign err_o   = e;

  // mode 1 outside the band drives P alone
  always_comb begin
    if (cfg_i.mode == pidb_pkg::MODE_BAND && !flag_o) begin
      pd_sel    = PDW'(p_term);
      integ_use = '0;
    end else begin
      pd_sel    = PDW'(p_term) + PDW'(d_term);
      integ_use = integ_new;
    end
  end

  // exact Q.2F drive, truncated toward zero
  assign total = TW'(pd_sel) + (TW'(integ_use) <<< FRAC_BITS);
  assign rnd   = total[TW-1] && (|total[2*FRAC_BITS-1:0]);
  assign q     = $signed(total[TW-1:2*FRAC_BITS]) + $signed({{(QW-1){1'b0}}, rnd});

  assign full    = {1'b0, pwm_max_i} + (PWM_BITS+1)'(1);
  assign pwm_ext = $signed(DRW'(pwm_max_i));
  assign drv     = forced ? $signed(DRW'(full)) : DRW'(q);

  always_comb begin
    if (drv[DRW-1])         duty_o = '0;
    else if (drv > pwm_ext) duty_o = full;
    else                    duty_o = drv[PWM_BITS:0];
  end

  assign raw_ovf = !((&drv[DRW-1:31]) || !(|drv[DRW-1:31]));
  assign raw_drive_o = raw_ovf ? (drv[DRW-1] ? 32'sh8000_0000 : 32'sh7fff_ffff)
                               : drv[31:0];

endmodule

// ===== sim/pid_drive_checker.sv =====
module pid_drive_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel_i,
  input  logic                          penable_i,
  input  logic                          pwrite_i,
  input  logic                          pready_i,
  input  logic [pidb_pkg::ADDR_W-1:0]   paddr_i,
  input  logic [31:0]                   pwdata_i,
  input  logic                          in_valid_i,
  input  logic                          in_stall_i,
  input  logic signed [31:0]            setpoint_i,
  input  logic signed [31:0]            measurement_i,
  input  logic                          out_valid_i,
  input  logic                          out_stall_i,
  input  logic [16:0]                   duty_i,
  input  logic signed [31:0]            raw_drive_i,
  input  logic                          in_band_i,
  output int                            pending_o,
  output int                            fail_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint INTEG_HI = 64'sd140737488355327;
  localparam longint INTEG_LO = -INTEG_HI - 1;
  localparam longint S32_HI   = 64'sd2147483647;
  localparam longint S32_LO   = -64'sd2147483648;

  typedef struct packed {
    logic [16:0]        duty;
    logic signed [31:0] raw;
    logic               in_band;
  } drive_t;

  drive_t expected_q[$];

  // shadow of the register file
  logic signed [pidb_pkg::GAIN_W-1:0] kp_r, ki_r, kd_r;
  logic [1:0]                         mode_r;
  logic [pidb_pkg::BAND_W-1:0]        band_r;
  logic [15:0]                        pwm_max_r;

  // controller state
  longint prev_err;
  longint integ;
  logic   band_flag;

  task automatic report(string what, longint got, longint want);
    if (fail_count_o < 100)
      $display("%0t: %s mismatch, got %0d, expected %0d", $time, what, got, want);
    fail_count_o++;
  endtask

  function automatic void apply_write(logic [2:0] idx, logic [31:0] data);
    case (idx)
      pidb_pkg::REG_KP: kp_r = data[pidb_pkg::GAIN_W-1:0];
      pidb_pkg::REG_KI: begin
        ki_r  = data[pidb_pkg::GAIN_W-1:0];
        integ = 0;
      end
      pidb_pkg::REG_KD: kd_r = data[pidb_pkg::GAIN_W-1:0];
      pidb_pkg::REG_MODE: begin
        mode_r    = data[1:0];
        prev_err  = 0;
        integ     = 0;
        band_flag = 1'b0;
      end
      pidb_pkg::REG_BAND:    band_r    = data[pidb_pkg::BAND_W-1:0];
      pidb_pkg::REG_PWM_MAX: pwm_max_r = data[15:0];
      default: ;
    endcase
  endfunction

  function automatic void accumulate(longint inc);
    longint s;
    s = integ + inc;
    if (s > INTEG_HI) s = INTEG_HI;
    if (s < INTEG_LO) s = INTEG_LO;
    integ = s;
  endfunction

  function automatic drive_t step_controller(logic signed [31:0] sp, logic signed [31:0] ms);
    longint e, d, mag, band, full, drv, step_full, step_half;
    logic signed [127:0] acc;
    logic use_id, forced;
    drive_t res;
    e         = longint'(sp) - longint'(ms);
    d         = e - prev_err;
    mag       = (e < 0) ? -e : e;
    band      = longint'(band_r);
    full      = longint'(pwm_max_r) + 1;
    step_full = (longint'(ki_r) * e) >>> 16;
    step_half = (longint'(ki_r) * e) >>> 17;
    prev_err  = e;
    use_id    = 1'b1;
    forced    = 1'b0;

    if (mode_r != pidb_pkg::MODE_PID) begin
      if (mag < band) band_flag = 1'b1;
      if (mag > band) band_flag = 1'b0;
    end

    case (mode_r)
      pidb_pkg::MODE_PID: accumulate(step_full);
      pidb_pkg::MODE_BAND: begin
        if (band_flag) accumulate(step_full);
        else use_id = 1'b0;
      end
      pidb_pkg::MODE_FORCE: begin
        if (band_flag) accumulate(step_full);
        forced = e > band;
      end
      default: begin
        accumulate(band_flag ? step_full : step_half);
        forced = e > band + 65536;
      end
    endcase

    // exact Q.32 sum, then truncate toward zero
    acc = longint'(kp_r) * e;
    if (use_id) acc = acc + longint'(kd_r) * d + integ * 65536;
    drv = 64'(acc / 128'sh1_0000_0000);
    if (forced) drv = full;

    if (drv < 0) res.duty = '0;
    else if (drv > longint'(pwm_max_r)) res.duty = full[16:0];
    else res.duty = drv[16:0];
    if (drv > S32_HI) res.raw = 32'sh7FFF_FFFF;
    else if (drv < S32_LO) res.raw = 32'sh8000_0000;
    else res.raw = drv[31:0];
    res.in_band = band_flag;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    drive_t want;
    if (!rst_ni) begin
      kp_r         = '0;
      ki_r         = '0;
      kd_r         = '0;
      mode_r       = pidb_pkg::MODE_PID;
      band_r       = pidb_pkg::BAND_RST[pidb_pkg::BAND_W-1:0];
      pwm_max_r    = 16'hFFFF;
      prev_err     = 0;
      integ        = 0;
      band_flag    = 1'b0;
      fail_count_o = 0;
      expected_q.delete();
      pending_o    = 0;
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i)
        apply_write(paddr_i[pidb_pkg::ADDR_W-1:2], pwdata_i);

      if (out_valid_i && !out_stall_i) begin
        if (expected_q.size() == 0) begin
          report("unexpected result, raw_drive", raw_drive_i, 0);
        end else begin
          want = expected_q.pop_front();
          if (duty_i !== want.duty) report("duty", duty_i, want.duty);
          if (raw_drive_i !== want.raw) report("raw_drive", raw_drive_i, want.raw);
          if (in_band_i !== want.in_band) report("in_band", in_band_i, want.in_band);
        end
      end

      if (in_valid_i && !in_stall_i)
        expected_q.push_back(step_controller(setpoint_i, measurement_i));

      pending_o = expected_q.size();
    end
  end

endmodule

// ===== sim/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // run ends with a failure once this many cycles have passed
  localparam int     CYCLE_LIMIT = 500000;
  localparam longint S32_HI      = 64'sd2147483647;
  localparam longint S32_LO      = -64'sd2147483648;
  localparam longint E_MAX       = 64'sd4294967295;

  // addresses past the register file; writes there must be ignored
  localparam logic [2:0] REG_UNUSED_LO = 3'd6;
  localparam logic [2:0] REG_UNUSED_HI = 3'd7;

  localparam logic [23:0] GAIN_MAX = 24'h7F_FFFF;
  localparam logic [23:0] GAIN_MIN = 24'h80_0000;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  // config port
  logic                          psel    = 1'b0;
  logic                          penable = 1'b0;
  logic                          pwrite  = 1'b0;
  logic [pidb_pkg::ADDR_W-1:0]   paddr   = '0;
  logic [31:0]                   pwdata  = '0;
  logic [31:0]                   prdata;
  logic                          pready;

  // sample and result channels
  logic                in_valid    = 1'b0;
  logic                in_stall;
  logic signed [31:0]  setpoint    = '0;
  logic signed [31:0]  measurement = '0;
  logic                out_valid;
  logic                out_stall   = 1'b0;
  logic [16:0]         duty;
  logic signed [31:0]  raw_drive;
  logic                in_band;

  int pending;
  int fail_count;
  int sent_count  = 0;
  int cycle_count = 0;

  // current band, used to aim errors right at its edges
  longint band_cur;

  always #10 clk_i = ~clk_i;

  pid_controller_banded_integral dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .setpoint_i    (setpoint),
    .measurement_i (measurement),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .duty_o        (duty),
    .raw_drive_o   (raw_drive),
    .in_band_o     (in_band)
  );

  pid_drive_checker drive_chk (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel_i        (psel),
    .penable_i     (penable),
    .pwrite_i      (pwrite),
    .pready_i      (pready),
    .paddr_i       (paddr),
    .pwdata_i      (pwdata),
    .in_valid_i    (in_valid),
    .in_stall_i    (in_stall),
    .setpoint_i    (setpoint),
    .measurement_i (measurement),
    .out_valid_i   (out_valid),
    .out_stall_i   (out_stall),
    .duty_i        (duty),
    .raw_drive_i   (raw_drive),
    .in_band_i     (in_band),
    .pending_o     (pending),
    .fail_count_o  (fail_count)
  );

  // Watchdog: a hung handshake or a lost result ends here.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  // All tasks below start and end right after a rising edge, before any
  // nonblocking update of that step has been made by the caller.

  // APB write: setup phase, access phase, then an idle phase so that a
  // following setup never lands in the same step as the release.
  task automatic apb_write(logic [2:0] idx, logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(negedge clk_i); while (!pready);
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  // Block is idle once every predicted result has come back.
  task automatic wait_idle();
    do @(negedge clk_i); while (pending != 0);
    @(posedge clk_i);
  endtask

  // Mostly back-to-back, some short gaps, a few long ones.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Offer one transaction and hold it until taken. Stall is sampled on the
  // falling edge, where every input and output has settled.
  task automatic send_sample(logic [31:0] sp, logic [31:0] ms);
    int gap;
    bit taken;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid    <= 1'b1;
    setpoint    <= sp;
    measurement <= ms;
    do begin
      @(negedge clk_i);
      taken = !in_stall;
      @(posedge clk_i);
    end while (!taken);
    sent_count++;
  endtask

  // Sample pair with a chosen error; the measurement is random and both
  // are shifted together when the setpoint would leave 32 bits.
  task automatic send_error(longint err);
    longint ms_l, sp_l;
    ms_l = longint'($signed($urandom));
    sp_l = ms_l + err;
    if (sp_l > S32_HI) begin
      ms_l -= sp_l - S32_HI;
      sp_l  = S32_HI;
    end else if (sp_l < S32_LO) begin
      ms_l += S32_LO - sp_l;
      sp_l  = S32_LO;
    end
    send_sample(sp_l[31:0], ms_l[31:0]);
  endtask

  // All registers, mode optional. Unused upper bits of each word carry junk, which
  // the block has to drop. Mode goes last, when written, since it clears the state.
  task automatic configure(logic [23:0] kp, logic [23:0] ki, logic [23:0] kd,
                           logic [30:0] band, logic [15:0] pwm, logic [1:0] mode,
                           bit write_mode);
    logic [31:0] junk;
    junk = $urandom;
    apb_write(pidb_pkg::REG_KP, {junk[31:24], kp});
    apb_write(pidb_pkg::REG_KI, {junk[23:16], ki});
    apb_write(pidb_pkg::REG_KD, {junk[15:8], kd});
    apb_write(pidb_pkg::REG_BAND, {junk[0], band});
    apb_write(pidb_pkg::REG_PWM_MAX, {junk[31:16], pwm});
    if (write_mode) apb_write(pidb_pkg::REG_MODE, {junk[29:0], mode});
    band_cur = longint'(band);
  endtask

  function automatic logic [23:0] pick_gain();
    case ($urandom_range(0, 2))
      0: return $urandom_range(0, 1) ? GAIN_MAX : GAIN_MIN;
      1: return 24'($signed($urandom_range(0, 262144)) - 131072);
      default: return 24'($urandom);
    endcase
  endfunction

  function automatic logic [30:0] pick_band();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return 31'h7FFF_FFFF;
      default: return 31'($urandom_range(1, 32'h8_0000));
    endcase
  endfunction

  function automatic logic [15:0] pick_pwm_max();
    case ($urandom_range(0, 3))
      0: return '0;
      1: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // One random transaction. big_pct sets the share of near full-scale
  // errors of one sign, which walk the integral into saturation.
  task automatic send_random(int big_pct, longint big_sign);
    int r;
    longint base, err;
    r = $urandom_range(0, 99);
    if (r < big_pct) begin
      send_error(big_sign * (E_MAX - $urandom_range(0, 4000)));
    end else if (r < big_pct + 25) begin
      send_sample($urandom, $urandom);
    end else begin
      // hover around the band edge and the forcing thresholds
      case ($urandom_range(0, 3))
        0: base = band_cur;
        1: base = band_cur + 65536;
        2: base = longint'($urandom_range(0, 32'(band_cur)));
        default: base = 0;
      endcase
      err = base + $signed($urandom_range(0, 8)) - 4;
      if ($urandom_range(0, 1)) err = -err;
      send_error(err);
    end
  endtask

  // Stimulus: directed edge cases in every mode, then random phases with
  // fresh register settings. Each phase starts only once the block is idle.
  initial begin : stimulus
    logic [1:0] mode_list[4];
    logic [1:0] mode_cur;
    logic [1:0] mode_new;
    int n_items;
    longint big_sign;

    mode_list = '{pidb_pkg::MODE_PID, pidb_pkg::MODE_BAND, pidb_pkg::MODE_FORCE,
                  pidb_pkg::MODE_HALF};
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: gain 1.0 so the drive tracks the error, band 3.0, a low
    // pwm_max so the duty clamp shows up
    configure(24'h01_0000, 24'h00_0800, 24'h00_4000, 31'h3_0000, 16'd1000,
              pidb_pkg::MODE_PID, 1'b0);
    foreach (mode_list[m]) begin
      wait_idle();
      apb_write(pidb_pkg::REG_MODE, {30'd0, mode_list[m]});
      send_error(band_cur - 1);          // just inside the band
      send_error(band_cur);              // on the edge, flag kept
      send_error(band_cur + 1);          // just outside, forcing in mode 2
      send_error(band_cur + 65536);      // mode 3 threshold, not yet forced
      send_error(band_cur + 65537);      // mode 3 forced
      send_sample(32'h7FFF_FFFF, 32'h8000_0000);  // largest positive error
      send_sample(32'h8000_0000, 32'h7FFF_FFFF);  // largest negative error
      in_valid <= 1'b0;
    end
    mode_cur = pidb_pkg::MODE_HALF;

    wait_idle();
    apb_write(REG_UNUSED_LO, $urandom);
    apb_write(REG_UNUSED_HI, $urandom);

    for (int ph = 0; ph < 10; ph++) begin
      wait_idle();
      big_sign = $urandom_range(0, 1) ? 1 : -1;
      n_items  = 50;
      case (ph)
        0: begin
          // every field at its top, nothing above pwm_max of zero
          configure(GAIN_MAX, GAIN_MAX, GAIN_MAX, 31'h7FFF_FFFF, 16'd0,
                    pidb_pkg::MODE_FORCE, 1'b1);
          mode_cur = pidb_pkg::MODE_FORCE;
        end
        1: begin
          // long positive run: integral and raw drive saturate
          configure(GAIN_MAX, GAIN_MAX, GAIN_MAX, 31'd0, 16'hFFFF,
                    pidb_pkg::MODE_PID, 1'b1);
          mode_cur = pidb_pkg::MODE_PID;
          big_sign = 1;
          n_items  = 320;
        end
        2: begin
          configure(GAIN_MIN, GAIN_MIN, GAIN_MIN, 31'd0, 16'hFFFF,
                    pidb_pkg::MODE_HALF, 1'b1);
          mode_cur = pidb_pkg::MODE_HALF;
        end
        default: begin
          // mode rewritten when it changes, else about half the time; if not,
          // the state carries over and only the ki write clears the integral
          mode_new = $urandom_range(0, 3);
          configure(pick_gain(), pick_gain(), pick_gain(), pick_band(),
                    pick_pwm_max(), mode_new,
                    mode_new != mode_cur || $urandom_range(0, 1));
          mode_cur = mode_new;
        end
      endcase
      repeat (n_items) send_random(ph == 1 ? 95 : 15, big_sign);
      in_valid <= 1'b0;
    end

    // drain, then wait for anything stray
    wait_idle();
    repeat (8) @(posedge clk_i);
    if (fail_count == 0)
      $display("tb: PASS");
    else
      $display("tb: FAIL");
    $finish;
  end

  // Receiver: calm stretches, short stall bursts, the odd long stall, and
  // one long hold-off while the sender keeps offering, so the block fills
  // and pushes back on its input.
  initial begin : receiver
    int r;
    bit long_hold_done;
    long_hold_done = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      r = $urandom_range(0, 99);
      if (!long_hold_done && sent_count >= 150) begin
        out_stall <= 1'b1;
        repeat (400) @(posedge clk_i);
        long_hold_done = 1'b1;
      end else if (r < 20) begin
        out_stall <= 1'b0;
        repeat ($urandom_range(20, 150)) @(posedge clk_i);
      end else if (r < 65) begin
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk_i);
      end else if (r < 95) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 3)) @(posedge clk_i);
      end else begin
        out_stall <= 1'b1;
        repeat ($urandom_range(10, 40)) @(posedge clk_i);
      end
    end
  end

endmodule
